FILE: sv/rtccl_pkg.sv
// ----------------------------------------------------------------------------
// rtccl_pkg
// Types, pattern text and helper functions of the RTC command line parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rtccl_pkg;

  // Request carried on the input channel: one character of command text
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_req_t;

  // Kind of command recognized at the final character
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_TIME  = 2'd1,
    KIND_DATE  = 2'd2,
    KIND_ALARM = 2'd3
  } cmd_kind_e;

  // Request carried on the output channel
  typedef struct packed {
    cmd_kind_e  command_kind;
    logic       range_error;
    logic [5:0] day_bcd;
    logic [4:0] month_bcd;
    logic [7:0] year_bcd;
    logic [5:0] hour_bcd;
    logic [6:0] minute_bcd;
  } out_req_t;

  // Pattern identifiers
  localparam int unsigned NUM_PAT = 3;
  localparam logic [1:0] PAT_TIME  = 2'd0;
  localparam logic [1:0] PAT_DATE  = 2'd1;
  localparam logic [1:0] PAT_ALARM = 2'd2;

  // Pattern text; a space matches any whitespace run, '#' marks a number field
  localparam logic [8*12-1:0] PAT_TEXT_TIME  = "set time #:#";
  localparam logic [8*14-1:0] PAT_TEXT_DATE  = "set date #.#.#";
  localparam logic [8*19-1:0] PAT_TEXT_ALARM = "set alarm #.#.# #:#";

  localparam logic [4:0] PAT_LEN    [NUM_PAT] = '{5'd12, 5'd14, 5'd19};
  localparam logic [4:0] PAT_PREFIX [NUM_PAT] = '{5'd8, 5'd8, 5'd9};
  localparam logic [2:0] PAT_FIELDS [NUM_PAT] = '{3'd2, 3'd3, 3'd5};

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_FIELD = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Range limits
  localparam logic [7:0] MAX_HOUR   = 8'd23;
  localparam logic [7:0] MAX_MINUTE = 8'd59;
  localparam logic [7:0] MAX_DAY    = 8'd31;
  localparam logic [7:0] MAX_MONTH  = 8'd12;

  // Character of pattern k at position p, NUL past its end
  function automatic logic [7:0] pat_char(input logic [1:0] k, input logic [4:0] p);
    logic [7:0] ch;
    ch = CH_NUL;
    unique case (k)
      PAT_TIME: begin
        if (p < PAT_LEN[PAT_TIME])
          ch = PAT_TEXT_TIME[8*(int'(PAT_LEN[PAT_TIME])-1-int'(p)) +: 8];
      end
      PAT_DATE: begin
        if (p < PAT_LEN[PAT_DATE])
          ch = PAT_TEXT_DATE[8*(int'(PAT_LEN[PAT_DATE])-1-int'(p)) +: 8];
      end
      PAT_ALARM: begin
        if (p < PAT_LEN[PAT_ALARM])
          ch = PAT_TEXT_ALARM[8*(int'(PAT_LEN[PAT_ALARM])-1-int'(p)) +: 8];
      end
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Two-digit BCD of an 8-bit value; tens digit cut to four bits
  function automatic logic [7:0] bcd_of(input logic [7:0] v);
    logic [15:0] prod;
    logic [7:0]  tens;
    logic [7:0]  ones;
    prod = 16'(v) * 16'd205;
    tens = 8'(prod >> 11);
    ones = 8'(v - 8'((tens << 3) + (tens << 1)));
    return {tens[3:0], ones[3:0]};
  endfunction

endpackage

`default_nettype wire

FILE: sv/rtc_command_line_parser.sv
// ----------------------------------------------------------------------------
// rtc_command_line_parser
// Character-serial parser for set time, set date and set alarm commands.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one character per request with a flag on the
//   final character of a command. Three matchers follow the time, date and
//   alarm patterns side by side. The output channel carries one request per
//   command, issued for the final character only: the command kind, a range
//   error flag and the stored day, month, year, hour and minute in BCD.
// Timing:
//   A character is taken into an input register, then the matcher logic
//   updates state and, for a final character, loads the output register,
//   whose valid flag is registered. One character per cycle is sustained
//   while no final character is held by a stalled output; the rate is set by
//   the matcher update, which advances each pattern by up to three elements per character.
// Reset:
//   Matchers restart, stored settings clear to zero, both registers empty.
// Stall:
//   While the output is stalled, a final character waits in the input
//   register; other characters keep flowing until one final character is
//   held, then the input stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module rtc_command_line_parser #(
  parameter int unsigned FIELD_DIGITS = 2
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  rtccl_pkg::in_req_t   in_req_i,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  output rtccl_pkg::out_req_t  out_req_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i
);
  import rtccl_pkg::*;

  localparam int unsigned DCW = $clog2(FIELD_DIGITS + 1);
  localparam int unsigned FEED_STEPS = 3;

  typedef struct packed {
    logic           alive;
    logic [4:0]     pos;
    logic [DCW-1:0] dcnt;
    logic [2:0]     fconv;
    logic [7:0]     acc;
  } mstate_t;

  typedef struct packed {
    mstate_t st;
    logic    close;
  } mstep_t;

  // Close the current field: value is taken from acc by the caller
  function automatic mstep_t close_field(input mstep_t m);
    mstep_t r;
    r = m;
    r.st.fconv = r.st.fconv + 3'd1;
    r.st.pos   = r.st.pos + 5'd1;
    r.st.dcnt  = '0;
    r.close    = 1'b1;
    return r;
  endfunction

  // Advance one matcher by one character
  function automatic mstep_t feed_char(input mstate_t s_in, input logic [1:0] k,
                                       input logic [7:0] c);
    mstep_t     m;
    logic       done;
    logic [7:0] e;
    logic       ws;
    logic       dig;
    logic [7:0] dval;
    m.st  = s_in;
    m.close = 1'b0;
    done  = 1'b0;
    ws    = is_ws(c);
    dig   = is_digit(c);
    dval  = c - CH_ZERO;
    for (int i = 0; i < FEED_STEPS; i++) begin
      if (!done) begin
        e = pat_char(k, m.st.pos);
        if (!m.st.alive || (m.st.pos >= PAT_LEN[k])) begin
          done = 1'b1;
        end else if (m.st.pos < PAT_PREFIX[k]) begin
          if (c == e) m.st.pos = m.st.pos + 5'd1;
          else        m.st.alive = 1'b0;
          done = 1'b1;
        end else if (e == CH_SPACE) begin
          if (ws) done = 1'b1;
          else    m.st.pos = m.st.pos + 5'd1;
        end else if (e == CH_FIELD) begin
          if (m.st.dcnt == '0) begin
            if (ws) begin
              done = 1'b1;
            end else if (!dig) begin
              m.st.alive = 1'b0;
              done = 1'b1;
            end else begin
              m.st.acc  = dval;
              m.st.dcnt = DCW'(1);
              if (m.st.dcnt >= DCW'(FIELD_DIGITS)) m = close_field(m);
              done = 1'b1;
            end
          end else if (dig) begin
            m.st.acc  = 8'((m.st.acc << 3) + (m.st.acc << 1) + dval);
            m.st.dcnt = m.st.dcnt + DCW'(1);
            if (m.st.dcnt >= DCW'(FIELD_DIGITS)) m = close_field(m);
            done = 1'b1;
          end else begin
            // non-digit ends the field, then retry the same character
            m = close_field(m);
          end
        end else begin
          if (c == e) m.st.pos = m.st.pos + 5'd1;
          else        m.st.alive = 1'b0;
          done = 1'b1;
        end
      end
    end
    return m;
  endfunction

  // Close a field cut short by the end of the text
  function automatic mstep_t finish_field(input mstep_t m, input logic [1:0] k);
    mstep_t r;
    r = m;
    if (m.st.alive && (m.st.pos < PAT_LEN[k]) &&
        (pat_char(k, m.st.pos) == CH_FIELD) && (m.st.dcnt != '0))
      r = close_field(m);
    return r;
  endfunction

  // Input register
  in_req_t  in_q;
  logic     in_vld_q, in_vld_d;
  logic     in_take;
  logic     adv;
  logic     out_free;

  // Matcher state
  mstate_t  m_q [NUM_PAT];
  mstep_t   m_feed [NUM_PAT];
  mstep_t   m_fin [NUM_PAT];
  logic     ended_q, ended_d;

  // Closed field values, newest at index 0
  logic [1:0][7:0] tval_q, tval_d;
  logic [2:0][7:0] dval_q, dval_d;
  logic [4:0][7:0] aval_q, aval_d;

  // Stored settings
  logic [7:0] day_q, day_d, mon_q, mon_d, year_q, year_d, hour_q, hour_d, min_q, min_d;

  logic       match_time, match_date, match_alarm;
  cmd_kind_e  kind;
  logic       err;

  out_req_t   out_q, out_d;
  logic       out_vld_q, out_vld_d;

  // Handshake: a final character needs room in the output register
  assign out_free   = !out_vld_q || !out_stall_i;
  assign adv        = in_vld_q && (!in_q.last_char || out_free);
  assign in_stall_o = in_vld_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take)  in_vld_d = 1'b1;
    else if (adv) in_vld_d = 1'b0;
  end

  // Feed the character, then close pending fields at the end of a command
  always_comb begin
    for (int k = 0; k < NUM_PAT; k++) begin
      m_feed[k].st    = m_q[k];
      m_feed[k].close = 1'b0;
      if (adv && !ended_q) begin
        if (in_q.char_code == CH_NUL) begin
          m_feed[k] = finish_field(m_feed[k], 2'(k));
        end else begin
          m_feed[k] = feed_char(m_q[k], 2'(k), in_q.char_code);
        end
      end
      if (adv && in_q.last_char) m_fin[k] = finish_field(m_feed[k], 2'(k));
      else                       m_fin[k] = m_feed[k];
    end
  end

  // Shift closed fields into each pattern's value line
  always_comb begin
    tval_d = tval_q;
    dval_d = dval_q;
    aval_d = aval_q;
    if (m_fin[PAT_TIME].close)  tval_d = {tval_q[0], m_fin[PAT_TIME].st.acc};
    if (m_fin[PAT_DATE].close)  dval_d = {dval_q[1:0], m_fin[PAT_DATE].st.acc};
    if (m_fin[PAT_ALARM].close) aval_d = {aval_q[3:0], m_fin[PAT_ALARM].st.acc};
  end

  assign match_time  = m_fin[PAT_TIME].st.alive &&
                       (m_fin[PAT_TIME].st.fconv == PAT_FIELDS[PAT_TIME]);
  assign match_date  = m_fin[PAT_DATE].st.alive &&
                       (m_fin[PAT_DATE].st.fconv == PAT_FIELDS[PAT_DATE]);
  assign match_alarm = m_fin[PAT_ALARM].st.alive &&
                       (m_fin[PAT_ALARM].st.fconv == PAT_FIELDS[PAT_ALARM]);

  // Range check and store accepted commands
  always_comb begin
    kind   = KIND_NONE;
    err    = 1'b0;
    day_d  = day_q;
    mon_d  = mon_q;
    year_d = year_q;
    hour_d = hour_q;
    min_d  = min_q;
    if (adv && in_q.last_char) begin
      if (match_time) begin
        if ((tval_d[1] <= MAX_HOUR) && (tval_d[0] <= MAX_MINUTE)) begin
          hour_d = bcd_of(tval_d[1]);
          min_d  = bcd_of(tval_d[0]);
          kind   = KIND_TIME;
        end else begin
          err = 1'b1;
        end
      end
      if (match_date) begin
        if ((dval_d[2] <= MAX_DAY) && (dval_d[1] <= MAX_MONTH)) begin
          day_d  = bcd_of(dval_d[2]);
          mon_d  = bcd_of(dval_d[1]);
          year_d = bcd_of(dval_d[0]);
          kind   = KIND_DATE;
        end
      end
      if (match_alarm) begin
        if ((aval_d[4] <= MAX_DAY) && (aval_d[3] <= MAX_MONTH) &&
            (aval_d[1] <= MAX_HOUR) && (aval_d[0] <= MAX_MINUTE)) begin
          day_d  = bcd_of(aval_d[4]);
          mon_d  = bcd_of(aval_d[3]);
          year_d = bcd_of(aval_d[2]);
          hour_d = bcd_of(aval_d[1]);
          min_d  = bcd_of(aval_d[0]);
          kind   = KIND_ALARM;
        end else begin
          err = 1'b1;
        end
      end
    end
  end

  // Output request
  always_comb begin
    out_d.command_kind = kind;
    out_d.range_error  = err;
    out_d.day_bcd      = day_d[5:0];
    out_d.month_bcd    = mon_d[4:0];
    out_d.year_bcd     = year_d;
    out_d.hour_bcd     = hour_d[5:0];
    out_d.minute_bcd   = min_d[6:0];
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_free) out_vld_d = adv && in_q.last_char;
  end

  assign ended_d = (adv && !in_q.last_char) ? (ended_q || (in_q.char_code == CH_NUL))
                 : ((adv && in_q.last_char) ? 1'b0 : ended_q);

  // Control and stored state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      ended_q   <= 1'b0;
      for (int k = 0; k < NUM_PAT; k++) begin
        m_q[k] <= '{alive: 1'b1, pos: '0, dcnt: '0, fconv: '0, acc: '0};
      end
      tval_q <= '0;
      dval_q <= '0;
      aval_q <= '0;
      day_q  <= '0;
      mon_q  <= '0;
      year_q <= '0;
      hour_q <= '0;
      min_q  <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      ended_q   <= ended_d;
      for (int k = 0; k < NUM_PAT; k++) begin
        if (adv && in_q.last_char) begin
          m_q[k] <= '{alive: 1'b1, pos: '0, dcnt: '0, fconv: '0, acc: m_fin[k].st.acc};
        end else begin
          m_q[k] <= m_fin[k].st;
        end
      end
      tval_q <= tval_d;
      dval_q <= dval_d;
      aval_q <= aval_d;
      day_q  <= day_d;
      mon_q  <= mon_d;
      year_q <= year_d;
      hour_q <= hour_d;
      min_q  <= min_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) in_q <= in_req_i;
    if (adv && in_q.last_char) out_q <= out_d;
  end

  assign out_req_o   = out_q;
  assign out_valid_o = out_vld_q;

  // A new output request follows a final character
  a_out_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(adv && in_q.last_char))
    else $error("output request without a final character");

  // Characters other than the final one never wait
  a_mid_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !in_q.last_char) |-> adv)
    else $error("mid-command character held");

  // Matchers restart after each command
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_q.last_char) |=> (m_q[PAT_TIME].alive && m_q[PAT_DATE].alive &&
                                 m_q[PAT_ALARM].alive && (m_q[PAT_ALARM].pos == '0) &&
                                 !ended_q))
    else $error("matchers not restarted");

  // An accepted command carries no range error
  a_kind_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_q.range_error && (out_q.command_kind != KIND_NONE)))
    else $error("range error on accepted command");

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the RTC command line parser: a directed table of
// commands, then random well-formed, broken and noise commands, sent one
// character per request with random gaps and stalls on both channels. Every
// reply is compared field by field with a cycle-free model of the parser.
// ----------------------------------------------------------------------------

module testbench;
  import rtccl_pkg::*;

  localparam int FIELD_DIGITS = 2;
  localparam int RANDOM_ITEMS = 1450;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 40;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 10;

  localparam int PREFIX_LEN [3] = '{8, 8, 9};
  localparam int FIELD_CNT  [3] = '{2, 3, 5};
  localparam int SLOT_BASE  [3] = '{0, 2, 5};

  typedef struct {
    in_req_t   req;
    bit        typed;
    cmd_kind_e kind;
    bit        err;
  } char_item_t;

  typedef struct {
    string     text;
    int        nul_at;
    bit        typed;
    cmd_kind_e kind;
    bit        err;
  } cmd_row_t;

  // Clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #4 clk = ~clk;

  // Block ports
  in_req_t  in_req    = '0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  out_req_t out_req;
  logic     out_valid;
  logic     out_stall = 1'b0;

  rtc_command_line_parser #(
    .FIELD_DIGITS(FIELD_DIGITS)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_req_i   (in_req),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .out_req_o  (out_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall)
  );

  // Parser model state
  logic        m_alive   [3];
  logic [4:0]  m_pos     [3];
  logic [1:0]  m_digits  [3];
  logic [2:0]  m_fields  [3];
  logic [15:0] m_value   [10];
  logic [7:0]  m_setting [5];
  logic        m_ended;

  char_item_t   char_stream [$];
  out_req_t     reply_queue [$];
  byte unsigned cmd_text    [$];

  int          send_idx    = 0;
  int          send_gap    = 0;
  int          rx_count    = 0;
  int          rx_gap      = 0;
  int          hold_left   = 0;
  bit          hold_done   = 1'b0;
  int          idle_cycles = 0;
  int          failures    = 0;
  logic [31:0] cycle_count = '0;

  // Directed commands; kind and error typed in where they are obvious
  cmd_row_t directed_rows [24] = '{
    '{"x",                          -1, 1'b1, KIND_NONE,  1'b0},
    '{"set time 00:00",             -1, 1'b1, KIND_TIME,  1'b0},
    '{"set time 23:59",             -1, 1'b1, KIND_TIME,  1'b0},
    '{"set time 24:00",             -1, 1'b1, KIND_NONE,  1'b1},
    '{"set time 12:60",             -1, 1'b1, KIND_NONE,  1'b1},
    '{"set date 31.12.99",          -1, 1'b1, KIND_DATE,  1'b0},
    '{"set date 32.1.0",            -1, 1'b1, KIND_NONE,  1'b0},
    '{"set date 1.13.5",            -1, 1'b1, KIND_NONE,  1'b0},
    '{"set alarm 31.12.99 23:59",   -1, 1'b1, KIND_ALARM, 1'b0},
    '{"set alarm 1.1.1 24:0",       -1, 1'b1, KIND_NONE,  1'b1},
    '{"set alarm 32.1.1 0:0",       -1, 1'b1, KIND_NONE,  1'b1},
    '{"set alarm 0.0.0 0:0",        -1, 1'b1, KIND_ALARM, 1'b0},
    '{"set time7:5",                -1, 1'b0, KIND_NONE,  1'b0},
    '{"set time \011\012\013 8:\014\0154", -1, 1'b0, KIND_NONE, 1'b0},
    '{"set date \0117 . 8.9",       -1, 1'b0, KIND_NONE,  1'b0},
    '{"set time 123:45",            -1, 1'b1, KIND_NONE,  1'b0},
    '{"set time -1:2",              -1, 1'b1, KIND_NONE,  1'b0},
    '{"set time 1:+2",              -1, 1'b1, KIND_NONE,  1'b0},
    '{"set time 4:3",               12, 1'b1, KIND_TIME,  1'b0},
    '{"set time 4:3xyz",            12, 1'b0, KIND_NONE,  1'b0},
    '{"set time 5:6",               11, 1'b1, KIND_NONE,  1'b0},
    '{"SET TIME 1:1",               -1, 1'b1, KIND_NONE,  1'b0},
    '{"set alarm 5.6.7 8:9\377\001", -1, 1'b0, KIND_NONE, 1'b0},
    '{"\377",                       -1, 1'b1, KIND_NONE,  1'b0}
  };

  // Runs of zero gaps on both sides for a quarter of the time
  wire calm = (cycle_count[9:8] == 2'b00);

  always @(posedge clk) cycle_count <= cycle_count + 32'd1;

  function automatic string pattern_text(int k);
    case (k)
      PAT_TIME: return "set time #:#";
      PAT_DATE: return "set date #.#.#";
      default:  return "set alarm #.#.# #:#";
    endcase
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_numeral(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic [7:0] to_bcd(logic [7:0] v);
    return 8'(((v / 8'd10) << 4) | (v % 8'd10));
  endfunction

  function automatic int value_slot(int k);
    int s;
    s = SLOT_BASE[k] + int'(m_fields[k]);
    return (s < 10) ? s : 9;
  endfunction

  function automatic void restart_matchers();
    for (int k = 0; k < 3; k++) begin
      m_alive[k]  = 1'b1;
      m_pos[k]    = '0;
      m_digits[k] = '0;
      m_fields[k] = '0;
    end
    m_ended = 1'b0;
  endfunction

  function automatic void close_field(int k);
    int s;
    s = value_slot(k);
    m_value[s]  = m_value[s] & 16'h00FF;
    m_fields[k] = m_fields[k] + 3'd1;
    m_pos[k]    = m_pos[k] + 5'd1;
    m_digits[k] = '0;
  endfunction

  // Close a field left open by the end of the text
  function automatic void end_field(int k);
    string ptxt;
    ptxt = pattern_text(k);
    if (m_alive[k] && m_pos[k] < ptxt.len() && m_digits[k] != 0 &&
        ptxt[m_pos[k]] == "#")
      close_field(k);
  endfunction

  // Advance one matcher by one character, sscanf style
  function automatic void feed_matcher(int k, logic [7:0] c);
    string      ptxt;
    logic [7:0] e;
    int         s;
    bit         done;
    ptxt = pattern_text(k);
    done = !m_alive[k];
    while (!done) begin
      if (m_pos[k] >= ptxt.len()) begin
        done = 1'b1;
      end else begin
        e = ptxt[m_pos[k]];
        if (m_pos[k] < PREFIX_LEN[k]) begin
          if (c == e) m_pos[k] = m_pos[k] + 5'd1;
          else m_alive[k] = 1'b0;
          done = 1'b1;
        end else if (e == " ") begin
          if (is_blank(c)) done = 1'b1;
          else m_pos[k] = m_pos[k] + 5'd1;
        end else if (e == "#") begin
          s = value_slot(k);
          if (m_digits[k] == 0) begin
            done = 1'b1;
            if (!is_blank(c)) begin
              if (!is_numeral(c)) begin
                m_alive[k] = 1'b0;
              end else begin
                m_value[s]  = 16'(c - 8'd48);
                m_digits[k] = 2'd1;
                if (m_digits[k] >= FIELD_DIGITS) close_field(k);
              end
            end
          end else if (is_numeral(c)) begin
            m_value[s]  = 16'(m_value[s] * 10 + (c - 8'd48));
            m_digits[k] = m_digits[k] + 2'd1;
            if (m_digits[k] >= FIELD_DIGITS) close_field(k);
            done = 1'b1;
          end else begin
            close_field(k);
          end
        end else begin
          if (c == e) m_pos[k] = m_pos[k] + 5'd1;
          else m_alive[k] = 1'b0;
          done = 1'b1;
        end
      end
    end
  endfunction

  function automatic bit fully_matched(int k);
    return m_alive[k] && (int'(m_fields[k]) == FIELD_CNT[k]);
  endfunction

  function automatic bit fits_date(int base);
    return (m_value[base][7:0] <= 8'd31) && (m_value[base + 1][7:0] <= 8'd12);
  endfunction

  function automatic bit fits_time(int base);
    return (m_value[base][7:0] <= 8'd23) && (m_value[base + 1][7:0] <= 8'd59);
  endfunction

  // Take one character; returns 1 with the reply on the final character
  function automatic bit parse_char(in_req_t r, output out_req_t reply);
    cmd_kind_e kind;
    bit        err;
    kind = KIND_NONE;
    err  = 1'b0;
    reply = '0;
    if (!m_ended) begin
      if (r.char_code == CH_NUL) begin
        for (int k = 0; k < 3; k++) end_field(k);
        m_ended = 1'b1;
      end else begin
        for (int k = 0; k < 3; k++) feed_matcher(k, r.char_code);
      end
    end
    if (!r.last_char) return 1'b0;
    for (int k = 0; k < 3; k++) end_field(k);

    if (fully_matched(PAT_TIME)) begin
      if (fits_time(0)) begin
        m_setting[3] = to_bcd(m_value[0][7:0]);
        m_setting[4] = to_bcd(m_value[1][7:0]);
        kind = KIND_TIME;
      end else begin
        err = 1'b1;
      end
    end
    if (fully_matched(PAT_DATE) && fits_date(2)) begin
      m_setting[0] = to_bcd(m_value[2][7:0]);
      m_setting[1] = to_bcd(m_value[3][7:0]);
      m_setting[2] = to_bcd(m_value[4][7:0]);
      kind = KIND_DATE;
    end
    if (fully_matched(PAT_ALARM)) begin
      if (fits_date(5) && fits_time(8)) begin
        m_setting[0] = to_bcd(m_value[5][7:0]);
        m_setting[1] = to_bcd(m_value[6][7:0]);
        m_setting[2] = to_bcd(m_value[7][7:0]);
        m_setting[3] = to_bcd(m_value[8][7:0]);
        m_setting[4] = to_bcd(m_value[9][7:0]);
        kind = KIND_ALARM;
      end else begin
        err = 1'b1;
      end
    end

    reply.command_kind = kind;
    reply.range_error  = err;
    reply.day_bcd      = m_setting[0][5:0];
    reply.month_bcd    = m_setting[1][4:0];
    reply.year_bcd     = m_setting[2];
    reply.hour_bcd     = m_setting[3][5:0];
    reply.minute_bcd   = m_setting[4][6:0];
    restart_matchers();
    return 1'b1;
  endfunction

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Upper end of the random value for field f of pattern k
  function automatic int field_span(int k, int f);
    case (k)
      PAT_TIME: return (f == 0) ? 29 : 69;
      PAT_DATE: return (f == 0) ? 39 : (f == 1) ? 15 : 99;
      default: begin
        case (f)
          0:       return 39;
          1:       return 15;
          2:       return 99;
          3:       return 29;
          default: return 69;
        endcase
      end
    endcase
  endfunction

  task automatic add_blanks(int n);
    int c;
    repeat (n) begin
      c = $urandom_range(0, 5);
      cmd_text.push_back((c == 5) ? 8'd32 : 8'(9 + c));
    end
  endtask

  task automatic add_number(int span);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      // leave the field empty
    end else if (r < 8) begin
      repeat (3) cmd_text.push_back(8'(48 + $urandom_range(0, 9)));
    end else begin
      v = $urandom_range(0, span);
      if (v >= 10 || $urandom_range(0, 1) == 1)
        cmd_text.push_back(8'(48 + v / 10));
      cmd_text.push_back(8'(48 + v % 10));
    end
  endtask

  // Mostly well-formed commands with random content, some broken, some noise
  task automatic build_random_command();
    int           k;
    int           f;
    int           pos;
    byte unsigned e;
    string        ptxt;
    cmd_text.delete();
    if ($urandom_range(0, 99) < 12) begin
      repeat ($urandom_range(1, 24)) cmd_text.push_back(8'($urandom_range(0, 255)));
    end else begin
      k = $urandom_range(0, 2);
      ptxt = pattern_text(k);
      f = 0;
      for (int p = 0; p < ptxt.len(); p++) begin
        e = ptxt[p];
        if (p < PREFIX_LEN[k]) begin
          if ($urandom_range(0, 149) == 0) cmd_text.push_back(8'($urandom_range(0, 255)));
          else cmd_text.push_back(e);
        end else if (e == " ") begin
          add_blanks($urandom_range(0, 3));
        end else if (e == "#") begin
          if ($urandom_range(0, 3) == 0) add_blanks($urandom_range(1, 2));
          if ($urandom_range(0, 49) == 0)
            cmd_text.push_back(($urandom_range(0, 1) == 1) ? "+" : "-");
          add_number(field_span(k, f));
          f++;
        end else if ($urandom_range(0, 39) == 0) begin
          cmd_text.push_back(8'($urandom_range(0, 255)));
        end else begin
          cmd_text.push_back(e);
        end
      end
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 5)) cmd_text.push_back(8'($urandom_range(0, 255)));
    end
    // Cut the text short with a NUL now and then
    if ($urandom_range(0, 15) == 0) begin
      pos = $urandom_range(0, cmd_text.size());
      if (pos == cmd_text.size()) cmd_text.push_back(CH_NUL);
      else cmd_text.insert(pos, CH_NUL);
    end
  endtask

  // Turn the command text into requests, flagging the final character
  task automatic queue_command(bit typed, cmd_kind_e kind, bit err);
    char_item_t it;
    for (int i = 0; i < cmd_text.size(); i++) begin
      it.req.char_code = cmd_text[i];
      it.req.last_char = (i == cmd_text.size() - 1);
      it.typed = typed && it.req.last_char;
      it.kind  = kind;
      it.err   = err;
      char_stream.push_back(it);
    end
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  // Sender: offer characters with random gaps, predict on acceptance
  always @(posedge clk) begin
    bit       accepted;
    out_req_t reply;
    if (rst_n) begin
      accepted = in_valid && !in_stall;
      if (accepted) begin
        if (parse_char(char_stream[send_idx].req, reply)) begin
          if (char_stream[send_idx].typed) begin
            reply.command_kind = char_stream[send_idx].kind;
            reply.range_error  = char_stream[send_idx].err;
          end
          reply_queue.push_back(reply);
        end
        send_idx++;
        send_gap = calm ? 0 : draw_gap();
      end
      if (in_valid && !accepted) begin
        // hold the stalled request
      end else if (send_gap > 0 || send_idx >= char_stream.size()) begin
        in_valid <= 1'b0;
        if (send_gap > 0) send_gap--;
      end else begin
        in_valid <= 1'b1;
        in_req   <= char_stream[send_idx].req;
      end
    end
  end

  // Receiver: random stalls, and one long hold-off to back up the block
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) rx_count++;
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!hold_done && rx_count >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (rx_gap > 0) begin
        out_stall <= 1'b1;
        rx_gap--;
      end else begin
        out_stall <= 1'b0;
        rx_gap = calm ? 0 : draw_gap();
      end
    end
  end

  // Compare each reply with the oldest prediction; count idle cycles
  always @(posedge clk) begin
    out_req_t want;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (out_valid && !out_stall) begin
        if (reply_queue.size() == 0) begin
          $error("reply with no prediction pending: kind %0d", out_req.command_kind);
          failures++;
        end else begin
          want = reply_queue.pop_front();
          check_field("command_kind", want.command_kind, out_req.command_kind);
          check_field("range_error", want.range_error, out_req.range_error);
          check_field("day_bcd", want.day_bcd, out_req.day_bcd);
          check_field("month_bcd", want.month_bcd, out_req.month_bcd);
          check_field("year_bcd", want.year_bcd, out_req.year_bcd);
          check_field("hour_bcd", want.hour_bcd, out_req.hour_bcd);
          check_field("minute_bcd", want.minute_bcd, out_req.minute_bcd);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  // Build the stimulus, release reset, drain and report
  initial begin
    int directed_items;
    restart_matchers();
    for (int i = 0; i < 10; i++) m_value[i] = '0;
    for (int i = 0; i < 5; i++) m_setting[i] = '0;

    foreach (directed_rows[r]) begin
      cmd_text.delete();
      for (int i = 0; i <= directed_rows[r].text.len(); i++) begin
        if (i == directed_rows[r].nul_at) cmd_text.push_back(CH_NUL);
        if (i < directed_rows[r].text.len()) cmd_text.push_back(directed_rows[r].text[i]);
      end
      queue_command(directed_rows[r].typed, directed_rows[r].kind, directed_rows[r].err);
    end
    directed_items = char_stream.size();
    while (char_stream.size() < directed_items + RANDOM_ITEMS) begin
      build_random_command();
      queue_command(1'b0, KIND_NONE, 1'b0);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (send_idx < char_stream.size()) @(posedge clk);
    while (reply_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
